>>> rtl/dns_name_decompress_assert.svh
// Assertion macros shared by the name decompressor RTL.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing when the code is read for synthesis.
`ifndef DNS_NAME_DECOMPRESS_ASSERT_SVH
`define DNS_NAME_DECOMPRESS_ASSERT_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define DND_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("dns_name_decompress: assertion failed");

// An implication checked in the same cycle.
`define DND_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dns_name_decompress: implication failed");

`else

`define DND_ASSERT(lbl, clk, rstn, prop)

`define DND_ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> rtl/dnd_pkg.sv
package dnd_pkg;

  // Walk pointer width: holds any 14-bit jump target and the store depth itself.
  localparam int WP_W = 15;

  localparam int PKT_DEPTH_DEF = 512;

  localparam int MAX_JUMPS_W = 7;
  localparam logic [MAX_JUMPS_W-1:0] MAX_JUMPS_RESET = 7'd16;

  localparam logic [8:0] NAME_CAP = 9'd256;
  localparam logic [7:0] PTR_MARK = 8'd192;
  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [9:0] CONS_MAX = 10'd1023;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_JUMPS = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  localparam int QDEPTH = 2;

  typedef enum logic {
    CMD_LOAD,
    CMD_DECODE
  } cmd_op_e;

  typedef struct packed {
    logic       func;
    logic [8:0] offset;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] chars;
    logic [2:0]  char_count;
    logic        last;
    logic [9:0]  consumed_len;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    cmd_op_e    op;
    logic [8:0] offset;
    logic [7:0] data;
  } cmd_t;

endpackage

>>> rtl/dnd_front.sv
module dnd_front import dnd_pkg::*; #(
  parameter int PKT_DEPTH = PKT_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output cmd_t     cmd_o
);

  logic       fr_valid_q, fr_valid_d;
  cmd_t       fr_cmd_q;
  logic       accept;
  logic       keep;
  logic [WP_W-1:0] off_ext;

  assign in_stall_o = fr_valid_q && !cmd_ready_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign off_ext    = WP_W'(in_data_i.offset);

  // Loads aimed past the store end are taken and dropped here.
  assign keep = (in_data_i.func == FUNC_DECODE) || (off_ext < WP_W'(PKT_DEPTH));

  always_comb begin
    fr_valid_d = fr_valid_q;
    if (fr_valid_q && cmd_ready_i) begin
      fr_valid_d = 1'b0;
    end
    if (accept) begin
      fr_valid_d = keep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && keep) begin
      fr_cmd_q.op     <= (in_data_i.func == FUNC_DECODE) ? CMD_DECODE : CMD_LOAD;
      fr_cmd_q.offset <= in_data_i.offset;
      fr_cmd_q.data   <= in_data_i.data_byte;
    end
  end

  assign cmd_valid_o = fr_valid_q;
  assign cmd_o       = fr_cmd_q;

endmodule

>>> rtl/dnd_queue.sv
module dnd_queue import dnd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t item_i,
  output logic ready_o,
  output logic valid_o,
  output cmd_t item_o,
  input  logic pop_i
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;

  cmd_t             entries_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = count_q < CNT_W'(QDEPTH);
  assign valid_o = count_q != '0;
  assign item_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> rtl/dnd_back.sv
`include "dns_name_decompress_assert.svh"

module dnd_back import dnd_pkg::*; #(
  parameter int PKT_DEPTH = PKT_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [MAX_JUMPS_W-1:0] max_jumps_i,
  input  logic                   cmd_valid_i,
  input  cmd_t                   cmd_i,
  output logic                   cmd_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_item_t              out_data_o
);

  localparam int AW = $clog2(PKT_DEPTH);
  localparam logic [WP_W:0] DEPTH_X = (WP_W+1)'(PKT_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADDR = 3'd1;
  localparam logic [2:0] S_LEN  = 3'd2;
  localparam logic [2:0] S_PTR  = 3'd3;
  localparam logic [2:0] S_CHR  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_ERR  = 3'd6;

  logic [2:0]             state_q, state_d;
  logic                   emit_pass_q, emit_pass_d;
  logic [WP_W-1:0]        off_q, off_d;
  logic [WP_W-1:0]        wp_q, wp_d;
  logic [MAX_JUMPS_W-1:0] jumps_q, jumps_d;
  logic                   jumped_q, jumped_d;
  logic [WP_W-1:0]        cons_q, cons_d;
  logic [1:0]             status_q, status_d;
  logic [7:0]             len_q, len_d;
  logic [WP_W-1:0]        cptr_q, cptr_d;
  logic [7:0]             lrem_q, lrem_d;
  logic [8:0]             n_q, n_d;
  logic [31:0]            word_q, word_d;
  logic [2:0]             wcnt_q, wcnt_d;

  logic [7:0]      mem [PKT_DEPTH];
  logic            we;
  logic [AW-1:0]   wa;
  logic [7:0]      wd;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [7:0]      rdata_q;

  logic            out_valid_q;
  out_item_t       out_q;
  logic            out_free;
  logic            emit;
  out_item_t       emit_item;

  logic [WP_W-1:0] cmd_off_ext;
  logic [WP_W-1:0] wp_p1;
  logic [WP_W:0]   wp_plus_len;
  logic [WP_W:0]   wp_next_lbl;
  logic [WP_W-1:0] wp_minus_off;
  logic [WP_W-1:0] cptr_p1;
  logic [9:0]      cons_sat;
  logic            dot_need;

  assign out_free     = !out_valid_q || !out_stall_i;
  assign cmd_off_ext  = WP_W'(cmd_i.offset);
  assign wp_p1        = wp_q + WP_W'(1);
  assign wp_plus_len  = {1'b0, wp_q} + (WP_W+1)'(rdata_q);
  assign wp_next_lbl  = wp_plus_len + (WP_W+1)'(1);
  assign wp_minus_off = wp_q - off_q;
  assign cptr_p1      = cptr_q + WP_W'(1);
  assign cons_sat     = (cons_q > WP_W'(CONS_MAX)) ? CONS_MAX : cons_q[9:0];
  assign dot_need     = (n_q != '0) && (n_q < NAME_CAP);

  always_comb begin
    state_d     = state_q;
    emit_pass_d = emit_pass_q;
    off_d       = off_q;
    wp_d        = wp_q;
    jumps_d     = jumps_q;
    jumped_d    = jumped_q;
    cons_d      = cons_q;
    status_d    = status_q;
    len_d       = len_q;
    cptr_d      = cptr_q;
    lrem_d      = lrem_q;
    n_d         = n_q;
    word_d      = word_q;
    wcnt_d      = wcnt_q;
    cmd_pop_o   = 1'b0;
    we          = 1'b0;
    wa          = cmd_off_ext[AW-1:0];
    wd          = cmd_i.data;
    rd_en       = 1'b0;
    rd_addr     = wp_q[AW-1:0];
    emit        = 1'b0;
    emit_item   = '0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.op == CMD_LOAD) begin
            we = 1'b1;
          end else begin
            off_d       = cmd_off_ext;
            wp_d        = cmd_off_ext;
            jumps_d     = '0;
            jumped_d    = 1'b0;
            cons_d      = '0;
            emit_pass_d = 1'b0;
            n_d         = '0;
            word_d      = '0;
            wcnt_d      = '0;
            state_d     = S_ADDR;
          end
        end
      end

      S_ADDR: begin
        if ({1'b0, wp_q} >= DEPTH_X) begin
          status_d = STATUS_RANGE;
          state_d  = S_ERR;
        end else begin
          rd_en   = 1'b1;
          rd_addr = wp_q[AW-1:0];
          state_d = S_LEN;
        end
      end

      S_LEN: begin
        len_d = rdata_q;
        if (rdata_q == 8'd0) begin
          if (!emit_pass_q) begin
            if (!jumped_q) begin
              cons_d = wp_minus_off + WP_W'(1);
            end
            emit_pass_d = 1'b1;
            wp_d        = off_q;
            state_d     = S_ADDR;
          end else begin
            state_d = S_FIN;
          end
        end else if (rdata_q >= PTR_MARK) begin
          if (!emit_pass_q) begin
            if ({1'b0, wp_p1} >= DEPTH_X) begin
              status_d = STATUS_RANGE;
              state_d  = S_ERR;
            end else if (jumps_q >= max_jumps_i) begin
              status_d = STATUS_JUMPS;
              state_d  = S_ERR;
            end else begin
              if (!jumped_q) begin
                cons_d   = wp_minus_off + WP_W'(2);
                jumped_d = 1'b1;
              end
              jumps_d = jumps_q + MAX_JUMPS_W'(1);
              rd_en   = 1'b1;
              rd_addr = wp_p1[AW-1:0];
              state_d = S_PTR;
            end
          end else begin
            rd_en   = 1'b1;
            rd_addr = wp_p1[AW-1:0];
            state_d = S_PTR;
          end
        end else if (!emit_pass_q) begin
          if (wp_plus_len >= DEPTH_X) begin
            status_d = STATUS_RANGE;
            state_d  = S_ERR;
          end else begin
            wp_d    = wp_next_lbl[WP_W-1:0];
            state_d = S_ADDR;
          end
        end else if (dot_need && (wcnt_q == 3'd4)) begin
          // The word is full: hand it out before the separator goes in.
          if (out_free) begin
            emit                 = 1'b1;
            emit_item.chars      = word_q;
            emit_item.char_count = wcnt_q;
            word_d               = '0;
            wcnt_d               = '0;
          end
        end else begin
          if (dot_need) begin
            word_d[8*wcnt_q[1:0] +: 8] = DOT_CHAR;
            wcnt_d = wcnt_q + 3'd1;
            n_d    = n_q + 9'd1;
          end
          rd_en   = 1'b1;
          rd_addr = wp_p1[AW-1:0];
          cptr_d  = wp_p1;
          lrem_d  = rdata_q;
          state_d = S_CHR;
        end
      end

      S_PTR: begin
        wp_d    = WP_W'({len_q[5:0], rdata_q});
        state_d = S_ADDR;
      end

      S_CHR: begin
        if ((n_q < NAME_CAP) && (wcnt_q == 3'd4)) begin
          if (out_free) begin
            emit                 = 1'b1;
            emit_item.chars      = word_q;
            emit_item.char_count = wcnt_q;
            word_d               = '0;
            wcnt_d               = '0;
          end
        end else begin
          if (n_q < NAME_CAP) begin
            word_d[8*wcnt_q[1:0] +: 8] = rdata_q;
            wcnt_d = wcnt_q + 3'd1;
            n_d    = n_q + 9'd1;
          end
          if (lrem_q > 8'd1) begin
            rd_en   = 1'b1;
            rd_addr = cptr_p1[AW-1:0];
            cptr_d  = cptr_p1;
            lrem_d  = lrem_q - 8'd1;
          end else begin
            wp_d    = cptr_p1;
            state_d = S_ADDR;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          emit                   = 1'b1;
          emit_item.chars        = word_q;
          emit_item.char_count   = wcnt_q;
          emit_item.last         = 1'b1;
          emit_item.consumed_len = cons_sat;
          emit_item.status       = STATUS_OK;
          state_d                = S_IDLE;
        end
      end

      S_ERR: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_item.last   = 1'b1;
          emit_item.status = status_q;
          state_d          = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      emit_pass_q <= 1'b0;
      off_q       <= '0;
      wp_q        <= '0;
      jumps_q     <= '0;
      jumped_q    <= 1'b0;
      cons_q      <= '0;
      status_q    <= STATUS_OK;
      n_q         <= '0;
      wcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      emit_pass_q <= emit_pass_d;
      off_q       <= off_d;
      wp_q        <= wp_d;
      jumps_q     <= jumps_d;
      jumped_q    <= jumped_d;
      cons_q      <= cons_d;
      status_q    <= status_d;
      n_q         <= n_d;
      wcnt_q      <= wcnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    cptr_q <= cptr_d;
    lrem_q <= lrem_d;
    word_q <= word_d;
    if (emit) begin
      out_q <= emit_item;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DND_ASSERT_IMPL(a_err_shape, clk_i, rst_ni, out_valid_q && (out_q.status != STATUS_OK), out_q.last && (out_q.char_count == 3'd0) && (out_q.consumed_len == 10'd0))
  `DND_ASSERT_IMPL(a_mid_full, clk_i, rst_ni, out_valid_q && !out_q.last, out_q.char_count == 3'd4)
  `DND_ASSERT_IMPL(a_check_silent, clk_i, rst_ni, !emit_pass_q && (state_q != S_FIN) && (state_q != S_ERR), !emit)

endmodule

>>> rtl/dns_name_decompress.sv
// Channel   Direction  Handshake          Payload
// in        input      in_valid / stall   in_item_t: func, offset, data_byte
// out       output     out_valid / stall  out_item_t: chars, char_count, last,
//                                         consumed_len, status
// cfg       input      cfg_valid / ready  max_jumps (7 bits), always ready
//
// A load writes one byte into the store. A decode walks the name twice, first
// to check it and measure its consumed length, then to emit its text: each
// label passes the address and length states, each pointer also the pointer
// state; each name byte and each full word on the output walk adds a step.
// Reset is asynchronous and active low; the store holds no reset and needs no
// clearing pass. Either side may stall; the queue and output register decouple.
module dns_name_decompress import dnd_pkg::*; #(
  parameter int PKT_DEPTH = PKT_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data_i,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data_o,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [MAX_JUMPS_W-1:0] cfg_data_i
);

  // The jump limit register. Writes must only be made while the block is idle;
  // the block itself does not enforce this. The walker reads it directly.
  logic [MAX_JUMPS_W-1:0] max_jumps_q;

  // Command path between the front end and the queue.
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Command path between the queue and the walker.
  logic q_valid;
  logic q_pop;
  cmd_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_jumps_q <= MAX_JUMPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_jumps_q <= cfg_data_i;
    end
  end

  // The front end takes items, drops loads aimed past the store and turns
  // the rest into load or decode commands.
  dnd_front #(
    .PKT_DEPTH (PKT_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // A short queue lets new items arrive while the walker is busy.
  dnd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .item_i  (cmd),
    .ready_o (cmd_ready),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  // The walker owns the packet store, follows labels and pointers and packs
  // the name text into result words.
  dnd_back #(
    .PKT_DEPTH (PKT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_jumps_i (max_jumps_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_item),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

endmodule
